FILE: src/csrbk_pkg.sv
package csrbk_pkg;

    // Default field widths and the fixed-point format.
    localparam int KEY_BITS_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;
    localparam int FRAC_BITS     = 16;

    // Result queue between the accumulator and the output channel.
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;

    // Pipeline control shared by the top level and the multiplier stages.
    typedef struct packed {
        logic adv;   // the whole pipeline moves one stage
        logic conj;  // conjugate the row scale
    } ctrl_t;

endpackage

FILE: src/csrbk_if.sv
interface csrbk_in_if
    import csrbk_pkg::*;
#(
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [KEY_BITS-1:0]         key_a;
    logic [KEY_BITS-1:0]         key_b;
    logic signed [DATA_BITS-1:0] value_re;
    logic signed [DATA_BITS-1:0] value_im;
    logic signed [DATA_BITS-1:0] scale_re;
    logic signed [DATA_BITS-1:0] scale_im;
    logic                        last_entry;

    modport source (
        output valid, key_a, key_b, value_re, value_im, scale_re, scale_im, last_entry,
        input  ready
    );
    modport sink (
        input  valid, key_a, key_b, value_re, value_im, scale_re, scale_im, last_entry,
        output ready
    );
endinterface

interface csrbk_out_if
    import csrbk_pkg::*;
#(
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [KEY_BITS-1:0]         out_key_a;
    logic [KEY_BITS-1:0]         out_key_b;
    logic signed [DATA_BITS-1:0] sum_re;
    logic signed [DATA_BITS-1:0] sum_im;
    logic                        final_res;

    modport source (
        output valid, out_key_a, out_key_b, sum_re, sum_im, final_res,
        input  ready
    );
    modport sink (
        input  valid, out_key_a, out_key_b, sum_re, sum_im, final_res,
        output ready
    );
endinterface

FILE: src/complex_scale_reduce_by_key_top.sv
// A result enters the result queue when a request in stage 3 closes the open run or is a last entry;
// when one request does both, its closed run is queued ahead of its final result.
// Throughput: one request per cycle; the output channel moves one result per cycle, and
// the input stalls while more than two results wait in the 4-entry result queue.
// Reset (rst_n, asynchronous, active low) clears pipeline valid bits, the open run,
// the result queue pointers and the conjugate bit.
module complex_scale_reduce_by_key_top
    import csrbk_pkg::*;
#(
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    csrbk_in_if.sink     in_ch,
    csrbk_out_if.source  out_ch
);

    // The pipeline has four steps. Stage 0 registers the request, the multiplier
    // block forms the four partial products (stage 1) and the rounded, saturated
    // complex product (stage 2), and stage 3 folds the product into the open run.
    // All stages move together under one advance signal, which is held back only
    // when the result queue could not take the two results a request may cause.

    localparam int MAXV_BITS = DATA_BITS;

    logic conj_reg;

    // Stage 0: request register.
    logic                        v0_reg;
    logic [KEY_BITS-1:0]         ka0_reg, kb0_reg;
    logic signed [DATA_BITS-1:0] vr0_reg, vi0_reg, sr0_reg, si0_reg;
    logic                        last0_reg;

    // Stages 1 and 2: keys and flags travel beside the multiplier.
    logic                        v1_reg, v2_reg;
    logic [KEY_BITS-1:0]         ka1_reg, kb1_reg, ka2_reg, kb2_reg;
    logic                        last1_reg, last2_reg;
    logic signed [DATA_BITS-1:0] pr, pi;

    // Open run.
    logic                        run_open_reg, run_open_next;
    logic [KEY_BITS-1:0]         run_ka_reg, run_kb_reg;
    logic signed [DATA_BITS-1:0] acc_re_reg, acc_im_reg;
    logic signed [DATA_BITS-1:0] acc_re_next, acc_im_next;

    // Result queue.
    logic [KEY_BITS-1:0]         fifo_ka [FIFO_DEPTH];
    logic [KEY_BITS-1:0]         fifo_kb [FIFO_DEPTH];
    logic signed [DATA_BITS-1:0] fifo_re [FIFO_DEPTH];
    logic signed [DATA_BITS-1:0] fifo_im [FIFO_DEPTH];
    logic                        fifo_fin [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg, wr_ptr_b;
    logic [FIFO_CNT_BITS-1:0]    count_reg, count_next;

    ctrl_t ctrl;
    logic  adv;
    logic  fire;
    logic  match;
    logic  push_a, push_b, pop;

    function automatic logic signed [MAXV_BITS-1:0] sat_add(
        input logic signed [MAXV_BITS-1:0] a,
        input logic signed [MAXV_BITS-1:0] b
    );
        logic signed [MAXV_BITS:0] s;
        s = {a[MAXV_BITS-1], a} + {b[MAXV_BITS-1], b};
        if (s[MAXV_BITS] == s[MAXV_BITS-1])
            return s[MAXV_BITS-1:0];
        else if (s[MAXV_BITS])
            return {1'b1, {(MAXV_BITS-1){1'b0}}};
        else
            return {1'b0, {(MAXV_BITS-1){1'b1}}};
    endfunction

    // The queue must have room for two results before anything moves.
    assign adv       = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign ctrl.adv  = adv;
    assign ctrl.conj = conj_reg;

    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conj_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            conj_reg <= cfg_wdata;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_ch.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ka0_reg   <= in_ch.key_a;
            kb0_reg   <= in_ch.key_b;
            vr0_reg   <= in_ch.value_re;
            vi0_reg   <= in_ch.value_im;
            sr0_reg   <= in_ch.scale_re;
            si0_reg   <= in_ch.scale_im;
            last0_reg <= in_ch.last_entry;
            ka1_reg   <= ka0_reg;
            kb1_reg   <= kb0_reg;
            last1_reg <= last0_reg;
            ka2_reg   <= ka1_reg;
            kb2_reg   <= kb1_reg;
            last2_reg <= last1_reg;
        end
    end

    csrbk_cmul #(
        .DATA_BITS (DATA_BITS)
    ) u_cmul (
        .clk   (clk),
        .ctrl  (ctrl),
        .vr    (vr0_reg),
        .vi    (vi0_reg),
        .sr    (sr0_reg),
        .si    (si0_reg),
        .pr    (pr),
        .pi    (pi)
    );

    // Stage 3: an entry with the open run's key pair adds into it; any other
    // entry first sends the open run out and then starts a new one. A last
    // entry sends out its run with the final marker and leaves no run open.
    assign fire   = adv && v2_reg;
    assign match  = run_open_reg && (ka2_reg == run_ka_reg) && (kb2_reg == run_kb_reg);
    assign push_a = fire && run_open_reg && !match;
    assign push_b = fire && last2_reg;
    assign pop    = out_ch.valid && out_ch.ready;

    always_comb
    begin
        if (match)
        begin
            acc_re_next = sat_add(acc_re_reg, pr);
            acc_im_next = sat_add(acc_im_reg, pi);
        end
        else
        begin
            acc_re_next = pr;
            acc_im_next = pi;
        end
        run_open_next = !last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            run_ka_reg   <= '0;
            run_kb_reg   <= '0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
        end
        else if (fire)
        begin
            run_open_reg <= run_open_next;
            run_ka_reg   <= ka2_reg;
            run_kb_reg   <= kb2_reg;
            acc_re_reg   <= acc_re_next;
            acc_im_reg   <= acc_im_next;
        end
    end

    // The closed run goes in first, the final result after it.
    assign wr_ptr_b = wr_ptr_reg + FIFO_PTR_BITS'(push_a);

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            fifo_ka[wr_ptr_reg]  <= run_ka_reg;
            fifo_kb[wr_ptr_reg]  <= run_kb_reg;
            fifo_re[wr_ptr_reg]  <= acc_re_reg;
            fifo_im[wr_ptr_reg]  <= acc_im_reg;
            fifo_fin[wr_ptr_reg] <= 1'b0;
        end
        if (push_b)
        begin
            fifo_ka[wr_ptr_b]  <= ka2_reg;
            fifo_kb[wr_ptr_b]  <= kb2_reg;
            fifo_re[wr_ptr_b]  <= acc_re_next;
            fifo_im[wr_ptr_b]  <= acc_im_next;
            fifo_fin[wr_ptr_b] <= 1'b1;
        end
    end

    assign count_next = count_reg + FIFO_CNT_BITS'(push_a) + FIFO_CNT_BITS'(push_b)
                        - FIFO_CNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(push_a) + FIFO_PTR_BITS'(push_b);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(pop);
            count_reg  <= count_next;
        end
    end

    assign out_ch.valid     = (count_reg != '0);
    assign out_ch.out_key_a = fifo_ka[rd_ptr_reg];
    assign out_ch.out_key_b = fifo_kb[rd_ptr_reg];
    assign out_ch.sum_re    = fifo_re[rd_ptr_reg];
    assign out_ch.sum_im    = fifo_im[rd_ptr_reg];
    assign out_ch.final_res = fifo_fin[rd_ptr_reg];

`ifndef SYNTHESIS
    // The result queue never holds more entries than it has.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A last entry leaves no run open.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last2_reg) |=> !run_open_reg)
        else $error("run still open after last entry");

    // An entry that adds into the open run and is not last sends nothing out.
    a_merge_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && match && !last2_reg) |=> (count_reg <= $past(count_reg)))
        else $error("merged entry produced a result");
`endif

endmodule

FILE: src/csrbk_cmul.sv
module csrbk_cmul
    import csrbk_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                        clk,
    input  ctrl_t                       ctrl,
    input  logic signed [DATA_BITS-1:0] vr,
    input  logic signed [DATA_BITS-1:0] vi,
    input  logic signed [DATA_BITS-1:0] sr,
    input  logic signed [DATA_BITS-1:0] si,
    output logic signed [DATA_BITS-1:0] pr,
    output logic signed [DATA_BITS-1:0] pi
);

    localparam int PW = 2 * DATA_BITS + 1;
    localparam int SW = PW + 1;
    localparam int TW = SW - FRAC_BITS;

    logic signed [DATA_BITS:0]   si_x;
    logic signed [DATA_BITS:0]   si_c;
    logic signed [PW-1:0]        prr_next, pii_next, pri_next, pir_next;
    logic signed [PW-1:0]        prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [SW-1:0]        re_full, im_full;
    logic signed [DATA_BITS-1:0] pr_next, pi_next;
    logic signed [DATA_BITS-1:0] pr_reg, pi_reg;

    function automatic logic signed [DATA_BITS-1:0] sat_trunc(input logic signed [TW-1:0] x);
        logic [TW-DATA_BITS:0] upper;
        upper = x[TW-1:DATA_BITS-1];
        if ((&upper) || !(|upper))
            return x[DATA_BITS-1:0];
        else if (x[TW-1])
            return {1'b1, {(DATA_BITS-1){1'b0}}};
        else
            return {1'b0, {(DATA_BITS-1){1'b1}}};
    endfunction

    // The conjugate is kept one bit wider so the most negative value negates exactly.
    assign si_x = {si[DATA_BITS-1], si};
    assign si_c = ctrl.conj ? -si_x : si_x;

    assign prr_next = PW'(sr) * PW'(vr);
    assign pii_next = PW'(si_c) * PW'(vi);
    assign pri_next = PW'(sr) * PW'(vi);
    assign pir_next = PW'(si_c) * PW'(vr);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            prr_reg <= prr_next;
            pii_reg <= pii_next;
            pri_reg <= pri_next;
            pir_reg <= pir_next;
        end
    end

    // Dropping the fraction bits of a signed value rounds toward minus infinity.
    assign re_full = SW'(prr_reg) - SW'(pii_reg);
    assign im_full = SW'(pri_reg) + SW'(pir_reg);
    assign pr_next = sat_trunc(re_full[SW-1:FRAC_BITS]);
    assign pi_next = sat_trunc(im_full[SW-1:FRAC_BITS]);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            pr_reg <= pr_next;
            pi_reg <= pi_next;
        end
    end

    assign pr = pr_reg;
    assign pi = pi_reg;

endmodule

FILE: verif/complex_scale_reduce_by_key_top_tb.sv
`timescale 1ns / 1ps

module complex_scale_reduce_by_key_top_tb
    import csrbk_pkg::*;
();

    localparam int KB = KEY_BITS_DEF;
    localparam int DB = DATA_BITS_DEF;

    // Cycles to let pass after the last expected result before the block
    // counts as idle. A request that only extends a run produces nothing, so
    // it may still be in the pipeline when the queue runs dry.
    localparam int SETTLE_CYCLES = 8;

    // Length of the long receiver hold-off used to fill the result queue.
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [DB-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(DB-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(DB-1){1'b0}}};
    localparam sample_t ONE        = sample_t'(1) <<< FRAC_BITS;
    localparam sample_t HALF       = sample_t'(1) <<< (FRAC_BITS - 1);

    localparam logic signed [127:0] WIDE_MAX = (128'sd1 <<< (DB-1)) - 128'sd1;
    localparam logic signed [127:0] WIDE_MIN = -(128'sd1 <<< (DB-1));

    // One sparse tensor entry as it travels on the input channel.
    typedef struct packed {
        logic [KB-1:0] key_a;
        logic [KB-1:0] key_b;
        sample_t       value_re;
        sample_t       value_im;
        sample_t       scale_re;
        sample_t       scale_im;
        logic          last_entry;
    } entry_t;

    // One summed run as it leaves on the output channel.
    typedef struct packed {
        logic [KB-1:0] key_a;
        logic [KB-1:0] key_b;
        sample_t       sum_re;
        sample_t       sum_im;
        logic          final_res;
    } run_sum_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    csrbk_in_if  #(.KEY_BITS(KB), .DATA_BITS(DB)) in_ch ();
    csrbk_out_if #(.KEY_BITS(KB), .DATA_BITS(DB)) out_ch ();

    complex_scale_reduce_by_key_top #(
        .KEY_BITS  (KB),
        .DATA_BITS (DB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #5 clk = ~clk;

    // Safety net: the slowest correct run is well under a tenth of this.
    initial
    begin
        #5000000;
        $display("complex_scale_reduce_by_key_top_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Reduction model. It keeps its own copy of the open run and of the
    // conjugate bit, and queues the run sums that the block must produce.
    // ------------------------------------------------------------------
    logic     conj_mode = 1'b0;
    logic     run_live = 1'b0;
    logic [KB-1:0] open_key_a = '0;
    logic [KB-1:0] open_key_b = '0;
    sample_t  open_sum_re = '0;
    sample_t  open_sum_im = '0;
    run_sum_t expected_sums[$];

    int mismatches = 0;

    // Saturate a wide signed value to the Q16.16 data range.
    function automatic sample_t clamp(input logic signed [127:0] x);
        if (x > WIDE_MAX)
            return SAMPLE_MAX;
        if (x < WIDE_MIN)
            return SAMPLE_MIN;
        return x[DB-1:0];
    endfunction

    function automatic sample_t add_sat(input sample_t a, input sample_t b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return clamp(wa + wb);
    endfunction

    // Exact complex product, then an arithmetic shift (floor) and a clamp.
    // The conjugated scale is kept 128 bits wide, so negating the most
    // negative imaginary part gives the true positive value.
    function automatic void scale_entry(input entry_t e, input logic conj,
                                        output sample_t p_re, output sample_t p_im);
        logic signed [127:0] vr;
        logic signed [127:0] vi;
        logic signed [127:0] sr;
        logic signed [127:0] si;
        vr = e.value_re;
        vi = e.value_im;
        sr = e.scale_re;
        si = e.scale_im;
        if (conj)
            si = -si;
        p_re = clamp((sr * vr - si * vi) >>> FRAC_BITS);
        p_im = clamp((sr * vi + si * vr) >>> FRAC_BITS);
    endfunction

    // Fold one accepted request into the open run. A key change closes the
    // run first; a last entry then flushes whatever run is open.
    function automatic void fold_entry(input entry_t e);
        sample_t p_re;
        sample_t p_im;
        scale_entry(e, conj_mode, p_re, p_im);
        if (run_live && e.key_a == open_key_a && e.key_b == open_key_b)
        begin
            open_sum_re = add_sat(open_sum_re, p_re);
            open_sum_im = add_sat(open_sum_im, p_im);
        end
        else
        begin
            if (run_live)
                expected_sums.push_back('{open_key_a, open_key_b, open_sum_re,
                                          open_sum_im, 1'b0});
            run_live    = 1'b1;
            open_key_a  = e.key_a;
            open_key_b  = e.key_b;
            open_sum_re = p_re;
            open_sum_im = p_im;
        end
        if (e.last_entry)
        begin
            expected_sums.push_back('{open_key_a, open_key_b, open_sum_re,
                                      open_sum_im, 1'b1});
            run_live = 1'b0;
        end
    endfunction

    // Every request accepted by the block goes through the model.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            fold_entry('{in_ch.key_a, in_ch.key_b, in_ch.value_re, in_ch.value_im,
                         in_ch.scale_re, in_ch.scale_im, in_ch.last_entry});
    end

    // ------------------------------------------------------------------
    // Result checking: each accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic flag_result(input string why, input run_sum_t want,
                               input run_sum_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %h/%h %0d %0d %b, got %h/%h %0d %0d %b",
                     $realtime, why, want.key_a, want.key_b, $signed(want.sum_re),
                     $signed(want.sum_im), want.final_res, got.key_a, got.key_b,
                     $signed(got.sum_re), $signed(got.sum_im), got.final_res);
    endtask

    always @(posedge clk)
    begin : check_results
        run_sum_t got;
        run_sum_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.out_key_a, out_ch.out_key_b, out_ch.sum_re, out_ch.sum_im,
                    out_ch.final_res};
            if (expected_sums.size() == 0)
                flag_result("unexpected result", '0, got);
            else
            begin
                want = expected_sums.pop_front();
                if (got.key_a !== want.key_a || got.key_b !== want.key_b ||
                    got.sum_re !== want.sum_re || got.sum_im !== want.sum_im ||
                    got.final_res !== want.final_res)
                    flag_result("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Before every result it draws a random stall when
    // rx_idle is set. A separate process can hold it off for a long,
    // counted stretch so that the result queue fills and the input stalls.
    // ------------------------------------------------------------------
    bit   tx_idle;
    bit   rx_idle;
    bit   hold_rx;
    event hold_go;

    initial
    begin
        forever
        begin
            @(hold_go);
            hold_rx = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx = 1'b0;
        end
    end

    initial
    begin : receiver
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 13) : 0;
            if (stall != 0 || hold_rx)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_rx) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid && !hold_rx);
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one request and return at the edge where it is accepted. Valid
    // stays high on return so that the next request can follow back to back.
    task automatic send_entry(input entry_t e);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.key_a      <= e.key_a;
        in_ch.key_b      <= e.key_b;
        in_ch.value_re   <= e.value_re;
        in_ch.value_im   <= e.value_im;
        in_ch.scale_re   <= e.scale_re;
        in_ch.scale_im   <= e.scale_im;
        in_ch.last_entry <= e.last_entry;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    function automatic entry_t mk_entry(input logic [KB-1:0] ka, input logic [KB-1:0] kb,
                                        input sample_t vr, input sample_t vi,
                                        input sample_t sr, input sample_t si,
                                        input logic last);
        return '{ka, kb, vr, vi, sr, si, last};
    endfunction

    // Stop offering and wait until every expected result has arrived and the
    // pipeline has had time to swallow requests that produce nothing.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The register is only written with the block idle.
    task automatic write_conjugate(input logic v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        conj_mode  = v;
    endtask

    // Moderate Q16.16 values most often, so sums stay meaningful, with full-range
    // words, the extremes and tiny raw values mixed in.
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 2**19) - 2**18;
            4, 5, 6:    return $urandom;
            7:          return SAMPLE_MAX;
            8:          return SAMPLE_MIN;
            default:    return $urandom_range(0, 2) - 1;
        endcase
    endfunction

    // A sorted list of runs with random content, closed by a last entry.
    // Now and then a key pair jumps to a random place, which the block must
    // treat as an ordinary key change.
    task automatic send_random_list(input int entries);
        entry_t        e;
        int            run_left;
        logic [KB-1:0] ka;
        logic [KB-1:0] kb;
        {ka, kb} = $urandom;
        run_left = 0;
        for (int i = 0; i < entries; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 5);
                case ($urandom_range(0, 7))
                    0:       {ka, kb} = $urandom;
                    1, 2:    begin ka = ka + 1'b1; kb = KB'($urandom); end
                    default: kb = kb + KB'($urandom_range(1, 3));
                endcase
            end
            run_left--;
            e = mk_entry(ka, kb, rand_sample(), rand_sample(), rand_sample(),
                         rand_sample(), i == entries - 1);
            send_entry(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Field extremes with the scale as given: saturation of products and of
    // the accumulator in both directions, floor rounding of small negative
    // products, a key change together with a last entry (two results from one
    // request), and a run reopened with the key of the run just flushed.
    task automatic test_directed_extremes();
        tx_idle = 1;
        rx_idle = 1;
        send_entry(mk_entry('0, '0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
        send_entry(mk_entry('0, '0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, '0, 1'b0));
        send_entry(mk_entry('0, KB'(1), -1, '0, 1, '0, 1'b0));
        send_entry(mk_entry('0, KB'(1), -3, 5, HALF, '0, 1'b0));
        send_entry(mk_entry('0, KB'(1), SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
        send_entry(mk_entry('0, KB'(1), SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
        send_entry(mk_entry('1, '1, ONE, ONE, ONE, '0, 1'b1));
        send_entry(mk_entry('1, '1, ONE, -ONE, '0, ONE, 1'b0));
        send_entry(mk_entry('1, '1, SAMPLE_MAX, SAMPLE_MIN, -ONE, -ONE, 1'b1));
        send_entry(mk_entry(KB'(16'h1234), KB'(16'h5678), '0, '0, '0, '0, 1'b1));
        send_entry(mk_entry(KB'(16'haaaa), KB'(16'h5555), SAMPLE_MIN, SAMPLE_MAX,
                            SAMPLE_MIN, SAMPLE_MIN, 1'b1));
        settle();
    endtask

    // Conjugated scale, including the most negative imaginary part, whose
    // negation must not wrap.
    task automatic test_conjugate_scale();
        write_conjugate(1'b1);
        send_entry(mk_entry(KB'(7), KB'(7), ONE, ONE, '0, SAMPLE_MIN, 1'b0));
        send_entry(mk_entry(KB'(7), KB'(7), SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                            SAMPLE_MIN, 1'b0));
        send_entry(mk_entry(KB'(7), KB'(8), -ONE, HALF, ONE, ONE, 1'b0));
        send_entry(mk_entry(KB'(7), KB'(9), ONE, '0, '0, SAMPLE_MAX, 1'b1));
        settle();
    endtask

    // The sender pauses in the middle of a run until every expected result
    // has come; the open run must survive the pause and keep summing.
    task automatic test_sender_pause();
        send_entry(mk_entry(KB'(100), KB'(1), ONE, HALF, ONE, -HALF, 1'b0));
        send_entry(mk_entry(KB'(100), KB'(1), -HALF, ONE, HALF, ONE, 1'b0));
        settle();
        send_entry(mk_entry(KB'(100), KB'(1), ONE, ONE, ONE, ONE, 1'b0));
        send_entry(mk_entry(KB'(100), KB'(2), HALF, -ONE, ONE, '0, 1'b1));
        settle();
    endtask

    // Long receiver hold-off while the sender keeps offering without gaps:
    // the result queue fills up and the block must stall its input.
    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        ->hold_go;
        send_random_list(40);
        send_random_list(40);
        settle();
    endtask

    // Random lists in several phases, the conjugate bit toggling between its
    // two values. Idling on either side is switched per list, so there are
    // stretches with no gaps as well as gaps on every phase of a run.
    task automatic test_random_lists();
        int sent;
        int len;
        int mode;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_conjugate(phase[0]);
            sent = 0;
            while (sent < 260)
            begin
                mode    = $urandom_range(0, 3);
                tx_idle = mode[0];
                rx_idle = mode[1];
                len     = $urandom_range(1, 24);
                send_random_list(len);
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.key_a      <= '0;
        in_ch.key_b      <= '0;
        in_ch.value_re   <= '0;
        in_ch.value_im   <= '0;
        in_ch.scale_re   <= '0;
        in_ch.scale_im   <= '0;
        in_ch.last_entry <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_conjugate_scale();
        test_sender_pause();
        test_backpressure();
        test_random_lists();

        settle();
        if (mismatches == 0 && expected_sums.size() == 0)
            $display("complex_scale_reduce_by_key_top_tb: clean");
        else
            $display("complex_scale_reduce_by_key_top_tb: errors");
        $finish;
    end

endmodule
